/* hdl/bis_pkg.sv */
// Package for the bilinear image scaler: request codes, register indexes
// and width constants.
// No dependencies.
package bis_pkg;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [1:0] REG_INV_SCALE  = 2'd0;
  localparam logic [1:0] REG_SRC_WIDTH  = 2'd1;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd2;

  localparam int unsigned CFG_WIDTH = 24;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WGT_BITS  = 8;

endpackage

/* hdl/bis_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module bis_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* hdl/bis_front.sv */
// Front end: maps destination coordinates to source base and weights.
// No dependencies. Two register stages: multiply, then clamp and weight.
module bis_front #(
  parameter int unsigned CoordBits = 12,
  parameter int unsigned XBits     = 8,
  parameter int unsigned YBits     = 8,
  parameter int unsigned MaxW      = 256,
  parameter int unsigned MaxH      = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_i,
  input  logic [CoordBits-1:0] col_i,
  input  logic [CoordBits-1:0] row_i,
  input  logic [23:0]          inv_scale_i,
  input  logic [8:0]           src_width_i,
  input  logic [8:0]           src_height_i,
  output logic                 valid_o,
  output logic [XBits-1:0]     x0_o,
  output logic [YBits-1:0]     y0_o,
  output logic [7:0]           xwi_o,
  output logic [7:0]           xwf_o,
  output logic [7:0]           ywi_o,
  output logic [7:0]           ywf_o
);

  localparam int unsigned PosBits = CoordBits + 24;
  localparam int unsigned IpBits  = PosBits - 16;
  localparam int unsigned SzBits  = (XBits > YBits ? XBits : YBits) + 1;

  logic               v1_q, v2_q;
  logic [PosBits-1:0] xpos_q, ypos_q;
  logic [SzBits-1:0]  w_q, h_q;
  logic [SzBits-1:0]  w_c, h_c;

  function automatic logic [SzBits-1:0] clamp_sz(logic [8:0] v, int unsigned mx);
    logic [SzBits:0] e;
    e = (SzBits+1)'(v);
    if (v < 9'd2) return SzBits'(2);
    if (e > (SzBits+1)'(mx)) return SzBits'(mx);
    return SzBits'(v);
  endfunction

  function automatic logic [7:0] wgt(logic [15:0] f);
    logic [23:0] p;
    p = {8'd0, f} * 24'd255;
    return p[23:16];
  endfunction

  function automatic logic [7:0] wgti(logic [15:0] f);
    logic [24:0] p;
    p = (25'd65536 - {9'd0, f}) * 25'd255;
    return p[23:16];
  endfunction

  assign w_c = clamp_sz(src_width_i, MaxW);
  assign h_c = clamp_sz(src_height_i, MaxH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i;
      v2_q <= v1_q;
    end
  end

  logic [IpBits-1:0] xip, yip;
  assign xip = xpos_q[PosBits-1:16];
  assign yip = ypos_q[PosBits-1:16];

  always_ff @(posedge clk_i) begin
    xpos_q <= PosBits'(col_i) * PosBits'(inv_scale_i);
    ypos_q <= PosBits'(row_i) * PosBits'(inv_scale_i);
    w_q    <= w_c;
    h_q    <= h_c;
    if (xip >= IpBits'(w_q - SzBits'(1))) x0_o <= XBits'(w_q - SzBits'(2));
    else x0_o <= XBits'(xip);
    if (yip >= IpBits'(h_q - SzBits'(1))) y0_o <= YBits'(h_q - SzBits'(2));
    else y0_o <= YBits'(yip);
    xwf_o <= wgt(xpos_q[15:0]);
    xwi_o <= wgti(xpos_q[15:0]);
    ywf_o <= wgt(ypos_q[15:0]);
    ywi_o <= wgti(ypos_q[15:0]);
  end

  assign valid_o = v2_q;

endmodule

/* hdl/bis_fifo.sv */
// Short request queue between front end and back end.
// No dependencies.
module bis_fifo #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned Aw = $clog2(Depth);

  logic [Width-1:0] buf_q [Depth];
  logic [Aw-1:0]    wp_q, rp_q;
  logic [Aw:0]      cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + Aw'(1);
      if (pop_i) rp_q <= rp_q + Aw'(1);
      cnt_q <= cnt_q + (Aw+1)'(push_i) - (Aw+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= data_i;
  end

  assign empty_o = (cnt_q == '0);
  assign data_o  = buf_q[rp_q];

endmodule

/* hdl/bis_back.sv */
// Back end: executes queued requests in order; a write goes straight to the
// RAM, a read fetches the 2x2 neighborhood as two row reads and blends channels.
// Depends on bis_pkg and bis_ram.
module bis_back #(
  parameter int unsigned XBits = 8,
  parameter int unsigned YBits = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    empty_i,
  input  logic [XBits+YBits+32:0] job_i,
  output logic                    pop_o,
  output logic                    done_o,
  output logic [31:0]             pixel_o
);

  localparam int unsigned Aw = XBits + YBits;

  logic             phase_q, rv1_q, rv2_q, bv_q;
  logic             op, we, rq;
  logic [Aw-1:0]    wa;
  logic [31:0]      wd;
  logic [XBits-1:0] x0;
  logic [YBits-1:0] y0;
  logic [YBits-1:0] yr;
  logic [Aw-1:0]    ra, rb;
  logic [31:0]      da, db, p00_q, p01_q;
  logic [7:0]       xwi, xwf, ywi, ywf;
  logic [31:0]      w1_q, w2_q, w3_q;
  logic [7:0]       top_q [4];
  logic [7:0]       bot_q [4];
  logic [7:0]       res_q [4];

  assign op = job_i[Aw+32];
  assign {x0, y0, xwi, xwf, ywi, ywf} = job_i[Aw+31:0];
  assign {wa, wd} = job_i[Aw+31:0];
  assign we = !empty_i && !phase_q && (op == bis_pkg::REQ_WRITE);
  assign rq = !empty_i && !phase_q && (op == bis_pkg::REQ_READ);
  assign yr = phase_q ? y0 + YBits'(1) : y0;
  assign ra = {yr, x0};
  assign rb = {yr, x0 + XBits'(1)};
  assign pop_o = phase_q || we;

  bis_ram #(.Width(32), .Depth(1 << Aw)) u_ram (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wd),
    .raddr_a_i(ra), .raddr_b_i(rb), .rdata_a_o(da), .rdata_b_o(db)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      rv1_q   <= 1'b0;
      rv2_q   <= 1'b0;
      bv_q    <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      phase_q <= rq;
      rv1_q   <= rq;
      rv2_q   <= phase_q;
      bv_q    <= rv2_q;
      done_o  <= bv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!phase_q) w1_q <= {xwi, xwf, ywi, ywf};
    w2_q <= w1_q;
    w3_q <= w2_q;
    if (rv1_q) begin
      p00_q <= da;
      p01_q <= db;
    end
    for (int c = 0; c < 4; c++) begin
      logic [15:0] t, b;
      t = 16'(p00_q[8*c +: 8]) * 16'(w2_q[31:24]) + 16'(p01_q[8*c +: 8]) * 16'(w2_q[23:16]);
      b = 16'(da[8*c +: 8]) * 16'(w2_q[31:24]) + 16'(db[8*c +: 8]) * 16'(w2_q[23:16]);
      if (rv2_q) begin
        top_q[c] <= t[15:8];
        bot_q[c] <= b[15:8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [15:0] v;
      v = 16'(top_q[c]) * 16'(w3_q[15:8]) + 16'(bot_q[c]) * 16'(w3_q[7:0]);
      res_q[c] <= v[15:8];
    end
  end

  assign pixel_o = {res_q[3], res_q[2], res_q[1], res_q[0]};

endmodule

/* hdl/bilinear_image_scaler_unit.sv */
// Top level of the bilinear image scaler: registers, front end, queue, back end.
// Depends on bis_pkg, bis_front, bis_fifo, bis_back.
// A read request gives one pixel; a source write gives none. Requests are
// taken every cycle while busy is low. Writes and reads pass through the same
// queue and take effect in order: a write needs one RAM access, a read a second
// one for the four frame reads over the two-port memory, so the back end pops
// no new request until both rows of a read are fetched. busy rises while six
// requests are in flight. With an empty queue a read passes the front-end
// registers, the queue, both row reads and both blends. done_o cannot stall.
module bilinear_image_scaler_unit #(
  parameter int unsigned MAX_SRC_WIDTH  = 256,
  parameter int unsigned MAX_SRC_HEIGHT = 256,
  parameter int unsigned COORD_BITS     = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [11:0] col_i,
  input  logic [11:0] row_i,
  input  logic [31:0] pixel_in_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  output logic        done_o,
  output logic [31:0] pixel_out_o
);

  localparam int unsigned XBits = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned YBits = $clog2(MAX_SRC_HEIGHT);
  localparam int unsigned JobW  = XBits + YBits + 32;
  localparam int unsigned QDepth = 8;

  logic [23:0] inv_q;
  logic [8:0]  w_q, h_q;
  logic        acc, rd, wr, fvalid, empty, pop;
  logic [XBits-1:0] x0;
  logic [YBits-1:0] y0;
  logic [7:0]  xwi, xwf, ywi, ywf;
  logic [JobW:0] job;
  logic [COORD_BITS-1:0] cc, rc;
  logic [3:0]  occ_q;
  logic        wv1_q, wv2_q;
  logic [XBits+YBits-1:0] wa1_q, wa2_q;
  logic [31:0] wd1_q, wd2_q;

  assign acc = start && !busy;
  assign rd  = acc && (req_type_i == bis_pkg::REQ_READ);
  assign wr  = acc && (req_type_i == bis_pkg::REQ_WRITE)
               && (32'(cc) < MAX_SRC_WIDTH) && (32'(rc) < MAX_SRC_HEIGHT);
  assign cc  = COORD_BITS'(col_i);
  assign rc  = COORD_BITS'(row_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 24'd65536;
      w_q   <= 9'd256;
      h_q   <= 9'd256;
      occ_q <= '0;
      wv1_q <= 1'b0;
      wv2_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bis_pkg::REG_INV_SCALE:  inv_q <= cfg_data_i;
          bis_pkg::REG_SRC_WIDTH:  w_q   <= cfg_data_i[8:0];
          bis_pkg::REG_SRC_HEIGHT: h_q   <= cfg_data_i[8:0];
          default: ;
        endcase
      end
      occ_q <= occ_q + 4'(rd || wr) - 4'(pop);
      wv1_q <= wr;
      wv2_q <= wv1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wa1_q <= {rc[YBits-1:0], cc[XBits-1:0]};
    wd1_q <= pixel_in_i;
    wa2_q <= wa1_q;
    wd2_q <= wd1_q;
  end

  assign busy = (occ_q >= 4'(QDepth - 2));

  bis_front #(
    .CoordBits(COORD_BITS), .XBits(XBits), .YBits(YBits),
    .MaxW(MAX_SRC_WIDTH), .MaxH(MAX_SRC_HEIGHT)
  ) u_front (
    .clk_i, .rst_ni, .req_i(rd), .col_i(cc), .row_i(rc),
    .inv_scale_i(inv_q), .src_width_i(w_q), .src_height_i(h_q),
    .valid_o(fvalid), .x0_o(x0), .y0_o(y0),
    .xwi_o(xwi), .xwf_o(xwf), .ywi_o(ywi), .ywf_o(ywf)
  );

  bis_fifo #(.Width(JobW + 1), .Depth(QDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(fvalid || wv2_q),
    .data_i(wv2_q ? {bis_pkg::REQ_WRITE, wa2_q, wd2_q}
                  : {bis_pkg::REQ_READ, x0, y0, xwi, xwf, ywi, ywf}),
    .pop_i(pop), .empty_o(empty), .data_o(job)
  );

  bis_back #(.XBits(XBits), .YBits(YBits)) u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .job_i(job), .pop_o(pop),
    .done_o(done_o), .pixel_o(pixel_out_o)
  );

endmodule
